[hdl/orfs_pkg.sv]
// Shared types, constants and base coding for the stop codon scanner.
package orfs_pkg;

    localparam int unsigned POSITION_BITS_DEF = 32;

    localparam logic [7:0] CHAR_G = 8'h47;
    localparam logic [7:0] CHAR_C = 8'h43;
    localparam logic [7:0] CHAR_A = 8'h41;

    localparam logic [31:0] OUT_MAX = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        BASE_G = 2'd0,
        BASE_C = 2'd1,
        BASE_A = 2'd2,
        BASE_T = 2'd3
    } base_t;

    typedef enum logic [1:0] {
        FRAME_0 = 2'd0,
        FRAME_1 = 2'd1,
        FRAME_2 = 2'd2
    } frame_t;

    typedef struct packed {
        logic [7:0] nucleotide;
        logic       first;
    } orfs_in_t;

    typedef struct packed {
        logic [31:0] orf_start;
        logic [31:0] orf_length;
        logic [31:0] longest_length;
    } orfs_out_t;

    function automatic base_t encode_base(input logic [7:0] ch);
        base_t b;
        case (ch)
            CHAR_G:  b = BASE_G;
            CHAR_C:  b = BASE_C;
            CHAR_A:  b = BASE_A;
            default: b = BASE_T;
        endcase
        return b;
    endfunction

    function automatic logic is_stop(input base_t b0, input base_t b1, input base_t b2);
        logic hit;
        hit = 1'b0;
        if (b0 == BASE_T) begin
            if (b1 == BASE_A) begin
                hit = (b2 == BASE_A) || (b2 == BASE_G);
            end else if (b1 == BASE_G) begin
                hit = (b2 == BASE_A);
            end
        end
        return hit;
    endfunction

endpackage

[hdl/orfs_core.sv]
// Scanner state and per-word datapath: codon check, frame lengths, longest length.
module orfs_core #(
    parameter int unsigned POSITION_BITS = orfs_pkg::POSITION_BITS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step,
    input  orfs_pkg::orfs_in_t in_word,
    output logic              hit,
    output orfs_pkg::orfs_out_t result
);

    localparam int unsigned PB = POSITION_BITS;
    localparam int unsigned PW = PB + 1;
    localparam int unsigned EW = (PW > 33) ? PW : 33;

    function automatic logic [31:0] sat32(input logic [EW-1:0] v);
        logic [31:0] r;
        if (v > {{(EW-32){1'b0}}, orfs_pkg::OUT_MAX}) begin
            r = orfs_pkg::OUT_MAX;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    orfs_pkg::base_t  recent0_reg, recent1_reg;
    logic [PB-1:0]    pos_reg, pos_next;
    orfs_pkg::frame_t phase_reg, phase_next;
    logic [PB-1:0]    start_reg [3];
    logic [PB-1:0]    start_next [3];
    logic [31:0]      longest_reg, longest_next;

    orfs_pkg::base_t  base;
    logic [PB-1:0]    pos_cur;
    orfs_pkg::frame_t phase_cur;
    logic [PB-1:0]    start_cur [3];
    logic [31:0]      longest_cur;
    logic             active;
    logic [PB-1:0]    s_sel;
    logic [PW-1:0]    len;
    logic [31:0]      len32;
    logic [PB-1:0]    pos_inc;

    always_comb begin
        base        = orfs_pkg::encode_base(in_word.nucleotide);
        pos_cur     = in_word.first ? '0 : pos_reg;
        phase_cur   = in_word.first ? orfs_pkg::FRAME_0 : phase_reg;
        longest_cur = in_word.first ? 32'd0 : longest_reg;
        for (int i = 0; i < 3; i++) begin
            start_cur[i] = in_word.first ? PB'(i) : start_reg[i];
        end
        active = (pos_cur >= PB'(2));
        case (phase_cur)
            orfs_pkg::FRAME_1: s_sel = start_cur[1];
            orfs_pkg::FRAME_2: s_sel = start_cur[2];
            default:           s_sel = start_cur[0];
        endcase
        if (pos_cur >= s_sel) begin
            len = {1'b0, pos_cur} - {1'b0, s_sel} + PW'(1);
        end else begin
            len = '0;
        end
        len32 = sat32(EW'(len));
        hit   = active && orfs_pkg::is_stop(recent1_reg, recent0_reg, base);
        pos_inc = (pos_cur == {PB{1'b1}}) ? pos_cur : pos_cur + PB'(1);

        result.orf_start      = sat32(EW'(s_sel));
        result.orf_length     = len32;
        result.longest_length = (len32 > longest_cur) ? len32 : longest_cur;

        pos_next = pos_inc;
        phase_next = phase_cur;
        if (active) begin
            case (phase_cur)
                orfs_pkg::FRAME_0: phase_next = orfs_pkg::FRAME_1;
                orfs_pkg::FRAME_1: phase_next = orfs_pkg::FRAME_2;
                default:           phase_next = orfs_pkg::FRAME_0;
            endcase
        end
        for (int i = 0; i < 3; i++) begin
            start_next[i] = start_cur[i];
        end
        if (hit) begin
            case (phase_cur)
                orfs_pkg::FRAME_1: start_next[1] = pos_inc;
                orfs_pkg::FRAME_2: start_next[2] = pos_inc;
                default:           start_next[0] = pos_inc;
            endcase
        end
        longest_next = hit ? result.longest_length : longest_cur;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            recent0_reg <= orfs_pkg::BASE_G;
            recent1_reg <= orfs_pkg::BASE_G;
            pos_reg     <= '0;
            phase_reg   <= orfs_pkg::FRAME_0;
            for (int i = 0; i < 3; i++) begin
                start_reg[i] <= PB'(i);
            end
            longest_reg <= '0;
        end else if (step) begin
            recent1_reg <= recent0_reg;
            recent0_reg <= base;
            pos_reg     <= pos_next;
            phase_reg   <= phase_next;
            for (int i = 0; i < 3; i++) begin
                start_reg[i] <= start_next[i];
            end
            longest_reg <= longest_next;
        end
    end

endmodule

[hdl/orf_stop_codon_scanner.sv]
// Top level: input word register, scanner core and result register.
// Three-frame stop codon scanner. One character word is taken per cycle unless
// s_ready is low; each result word passes the input register, then the result
// register. Only stop codons in frames past the first two characters give a
// result word. When m_ready is low, one result waits in the result register
// and one character in the input register; s_ready drops only when both are
// full (or in reset). Raising first restarts positions, frame starts and the
// longest length for a new sequence.
module orf_stop_codon_scanner #(
    parameter int unsigned POSITION_BITS = orfs_pkg::POSITION_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  orfs_pkg::orfs_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output orfs_pkg::orfs_out_t m_data
);

    logic                in_valid_reg, in_valid_next;
    orfs_pkg::orfs_in_t  in_word_reg, in_word_next;
    logic                out_valid_reg, out_valid_next;
    orfs_pkg::orfs_out_t out_word_reg, out_word_next;

    logic                advance;
    logic                hit;
    orfs_pkg::orfs_out_t result;

    orfs_core #(
        .POSITION_BITS(POSITION_BITS)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .in_word (in_word_reg),
        .hit     (hit),
        .result  (result)
    );

    always_comb begin
        advance = in_valid_reg && (!out_valid_reg || m_ready);
        s_ready = aresetn && (!in_valid_reg || advance);

        in_valid_next = in_valid_reg;
        in_word_next  = in_word_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
            in_word_next  = s_data;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        out_word_next  = out_word_reg;
        if (advance) begin
            out_valid_next = hit;
            out_word_next  = result;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
        in_word_reg  <= in_word_next;
        out_word_reg <= out_word_next;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_word_reg;

endmodule

[hdl/orfs_checker.sv]
// Port-level checks for the stop codon scanner, bound to the top level.
module orfs_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input orfs_pkg::orfs_out_t m_data
);

    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && !$past(s_ready))
        else $error("result or ready seen during reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result word changed");

    a_longest_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.orf_length <= m_data.longest_length)
        else $error("longest length below frame length");

    a_ready_free: assert property (@(posedge aclk) disable iff (!aresetn)
        aresetn && !m_valid |-> s_ready)
        else $error("input stalled with empty result register");

endmodule

bind orf_stop_codon_scanner orfs_checker u_orfs_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

[verif/orf_scan_checker.sv]
// Checker for the stop codon scanner: tracks accepted characters and compares result words.
module orf_scan_checker #(
    parameter int unsigned POSITION_BITS = orfs_pkg::POSITION_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_ready,
    input  orfs_pkg::orfs_in_t  s_data,
    input  logic                m_valid,
    input  logic                m_ready,
    input  orfs_pkg::orfs_out_t m_data,
    output int                  mismatches,
    output int                  pending_words,
    output int                  words_checked
);

    localparam logic [63:0] POS_LIMIT = (64'd1 << POSITION_BITS) - 64'd1;

    orfs_pkg::orfs_out_t expected_orfs[$];
    orfs_pkg::base_t     base_last;
    orfs_pkg::base_t     base_prev;
    logic [63:0]         seq_pos;
    orfs_pkg::frame_t    phase;
    logic [63:0]         frame_begin[3];
    logic [31:0]         longest;
    int                  mismatch_count = 0;
    int                  checked_count = 0;

    function automatic logic [31:0] clip32(input logic [63:0] v);
        return (v > {32'd0, orfs_pkg::OUT_MAX}) ? orfs_pkg::OUT_MAX : v[31:0];
    endfunction

    task automatic restart_sequence();
        seq_pos = '0;
        phase = orfs_pkg::FRAME_0;
        frame_begin[0] = 64'd0;
        frame_begin[1] = 64'd1;
        frame_begin[2] = 64'd2;
        longest = '0;
    endtask

    task automatic flag_mismatch(input string msg);
        $display("%0t: mismatch on result word %0d: %s", $time, checked_count, msg);
        mismatch_count++;
    endtask

    always @(posedge aclk) begin : scan_model
        orfs_pkg::base_t     b;
        logic [63:0]         p;
        logic [63:0]         s;
        logic [63:0]         len;
        logic [31:0]         len32;
        orfs_pkg::orfs_out_t orf;
        orfs_pkg::orfs_out_t want;
        int                  f;
        logic                stop;
        if (!aresetn) begin
            base_last = orfs_pkg::BASE_G;
            base_prev = orfs_pkg::BASE_G;
            restart_sequence();
            expected_orfs.delete();
        end else begin
            if (s_valid && s_ready) begin
                case (s_data.nucleotide)
                    orfs_pkg::CHAR_G: b = orfs_pkg::BASE_G;
                    orfs_pkg::CHAR_C: b = orfs_pkg::BASE_C;
                    orfs_pkg::CHAR_A: b = orfs_pkg::BASE_A;
                    default:          b = orfs_pkg::BASE_T;
                endcase
                if (s_data.first) begin
                    restart_sequence();
                end
                p = seq_pos;
                if (p >= 64'd2) begin
                    f = int'(phase);
                    stop = 1'b0;
                    if (base_prev == orfs_pkg::BASE_T) begin
                        if (base_last == orfs_pkg::BASE_A) begin
                            stop = (b == orfs_pkg::BASE_A) || (b == orfs_pkg::BASE_G);
                        end else if (base_last == orfs_pkg::BASE_G) begin
                            stop = (b == orfs_pkg::BASE_A);
                        end
                    end
                    if (stop) begin
                        s = frame_begin[f];
                        len = (p >= s) ? p - s + 64'd1 : 64'd0;
                        len32 = clip32(len);
                        if (len32 > longest) begin
                            longest = len32;
                        end
                        orf.orf_start = clip32(s);
                        orf.orf_length = len32;
                        orf.longest_length = longest;
                        expected_orfs.insert(expected_orfs.size(), orf);
                        frame_begin[f] = (p < POS_LIMIT) ? p + 64'd1 : POS_LIMIT;
                    end
                    case (phase)
                        orfs_pkg::FRAME_0: phase = orfs_pkg::FRAME_1;
                        orfs_pkg::FRAME_1: phase = orfs_pkg::FRAME_2;
                        default:           phase = orfs_pkg::FRAME_0;
                    endcase
                end
                base_prev = base_last;
                base_last = b;
                if (seq_pos < POS_LIMIT) begin
                    seq_pos = seq_pos + 64'd1;
                end
            end
            if (m_valid && m_ready) begin
                if (expected_orfs.size() == 0) begin
                    flag_mismatch($sformatf(
                        "no word expected, got start %0d length %0d longest %0d",
                        m_data.orf_start, m_data.orf_length, m_data.longest_length));
                end else begin
                    want = expected_orfs.pop_front();
                    if (m_data.orf_start !== want.orf_start) begin
                        flag_mismatch($sformatf("orf_start got %0d expected %0d",
                                                m_data.orf_start, want.orf_start));
                    end
                    if (m_data.orf_length !== want.orf_length) begin
                        flag_mismatch($sformatf("orf_length got %0d expected %0d",
                                                m_data.orf_length, want.orf_length));
                    end
                    if (m_data.longest_length !== want.longest_length) begin
                        flag_mismatch($sformatf("longest_length got %0d expected %0d",
                                                m_data.longest_length,
                                                want.longest_length));
                    end
                end
                checked_count++;
            end
        end
        mismatches <= mismatch_count;
        pending_words <= expected_orfs.size();
        words_checked <= checked_count;
    end

endmodule

[verif/orf_stop_codon_scanner_tb.sv]
// Testbench top for the stop codon scanner: clock, reset, stimulus, idling and verdict.
module orf_stop_codon_scanner_tb;

    localparam int RAND_WORDS   = 1150;
    localparam int TAIL_WORDS   = 150;
    localparam int LONG_HOLD    = 80;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 16;

    logic                aclk = 1'b0;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    orfs_pkg::orfs_in_t  s_data;
    logic                m_valid;
    logic                m_ready;
    orfs_pkg::orfs_out_t m_data;

    int   mismatches;
    int   pending_words;
    int   words_checked;
    logic tail_phase;
    logic long_hold_done = 1'b0;
    int   sender_odds = 4;
    int   quiet_cycles = 0;
    int   n;
    int   pick;
    logic [7:0] ch;

    orf_stop_codon_scanner dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    orf_scan_checker chk (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data        (s_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_data        (m_data),
        .mismatches    (mismatches),
        .pending_words (pending_words),
        .words_checked (words_checked)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    task automatic send_word(input logic [7:0] nt, input logic restart);
        orfs_pkg::orfs_in_t w;
        w.nucleotide = nt;
        w.first = restart;
        s_data <= w;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (!tail_phase && sender_odds != 0 && $urandom_range(1, sender_odds) == 1) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge aclk);
        end
    endtask

    task automatic send_text(input string txt, input logic restart);
        int i;
        for (i = 0; i < txt.len(); i++) begin
            send_word(txt[i], restart && i == 0);
        end
    endtask

    // result side: random stalls, one long hold-off once results are flowing
    initial begin
        m_ready <= 1'b0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            if (!long_hold_done && words_checked >= 12) begin
                long_hold_done = 1'b1;
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end else if (!tail_phase && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge aclk);
            end
        end
    end

    initial begin
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("orf_stop_codon_scanner verification failed");
        $finish;
    end

    initial begin
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_data <= '0;
        tail_phase <= 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // every kind of stop codon, and at least one in each frame
        send_text("TAA", 1'b1);
        send_text("ATGA", 1'b0);
        send_word(8'h00, 1'b0);
        send_word(8'hFF, 1'b0);
        send_text("GA", 1'b0);
        send_text("TAG", 1'b0);
        // lower case is not a base letter: all read as T
        send_text("taa", 1'b0);
        // restart right after T,A: no result for the leading bases
        send_text("TA", 1'b1);
        send_text("A", 1'b1);
        send_text("GTAA", 1'b0);

        for (n = 0; n < RAND_WORDS; n++) begin
            if (n % 64 == 0) begin
                sender_odds = 3 * $urandom_range(0, 4);
            end
            if (n == RAND_WORDS / 2) begin
                s_valid <= 1'b0;
                @(posedge aclk);
                while (pending_words != 0) @(posedge aclk);
            end
            if (n == RAND_WORDS - TAIL_WORDS) begin
                tail_phase <= 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 25) begin
                ch = orfs_pkg::CHAR_A + 8'd19;
            end else if (pick < 45) begin
                ch = orfs_pkg::CHAR_A;
            end else if (pick < 60) begin
                ch = orfs_pkg::CHAR_G;
            end else if (pick < 75) begin
                ch = orfs_pkg::CHAR_C;
            end else if (pick < 85) begin
                ch = orfs_pkg::CHAR_A + 8'd32 + 8'($urandom_range(0, 25));
            end else begin
                ch = 8'($urandom_range(0, 255));
            end
            send_word(ch, $urandom_range(0, 79) == 0);
        end
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_words != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatches == 0 && pending_words == 0) begin
            $display("orf_stop_codon_scanner verification clean");
        end else begin
            if (pending_words != 0) begin
                $display("%0d expected result words never arrived", pending_words);
            end
            $display("orf_stop_codon_scanner verification failed");
        end
        $finish;
    end

endmodule

[sim.f]
hdl/orfs_pkg.sv
hdl/orfs_core.sv
hdl/orf_stop_codon_scanner.sv
hdl/orfs_checker.sv
verif/orf_scan_checker.sv
verif/orf_stop_codon_scanner_tb.sv
